[rtl/scp_pkg.sv]
`default_nettype none
package scp_pkg;

	localparam int AddrW = 5;

	typedef enum logic [2:0] {
		REG_KIND     = 3'd0,
		REG_CENTER_X = 3'd1,
		REG_CENTER_Y = 3'd2,
		REG_DIR_X    = 3'd3,
		REG_DIR_Y    = 3'd4,
		REG_HALF_W   = 3'd5,
		REG_HALF_H   = 3'd6
	} reg_idx_t;

	localparam logic [1:0] MODE_POINT  = 2'd0;
	localparam logic [1:0] MODE_CIRCLE = 2'd1;
	localparam logic [1:0] MODE_RECT   = 2'd2;

	localparam logic signed [15:0] DIR_X_RESET = 16'sd16384;

	typedef struct packed {
		logic               kind;
		logic signed [15:0] cx;
		logic signed [15:0] cy;
		logic signed [15:0] dx;
		logic signed [15:0] dy;
		logic [14:0]        hw;
		logic [14:0]        hh;
	} ref_cfg_t;

	typedef struct packed {
		logic [1:0]  mode;
		logic [16:0] abs_tx;
		logic [16:0] abs_ty;
		logic [31:0] dot1;
		logic [31:0] dot2;
		logic [31:0] dot3;
		logic [31:0] dot4;
		logic [31:0] abs_c;
		logic [31:0] abs_s;
		logic [31:0] nrm;
		logic [30:0] rex;
		logic [30:0] rey;
		logic [30:0] pex;
		logic [30:0] pey;
		logic [14:0] phw;
		logic [14:0] phh;
		logic        cc_hit;
		logic        flat;
	} geom_t;

endpackage
`default_nettype wire

[rtl/scp_regs.sv]
`default_nettype none
module scp_regs (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       psel,
	input  logic                       penable,
	input  logic                       pwrite,
	input  logic [scp_pkg::AddrW-1:0]  paddr,
	input  logic [31:0]                pwdata,
	output logic [31:0]                prdata,
	output logic                       pready,
	output scp_pkg::ref_cfg_t          cfg
);
	import scp_pkg::*;

	ref_cfg_t cfg_q;
	reg_idx_t idx;
	logic     wr;

	assign idx    = reg_idx_t'(paddr[AddrW-1:2]);
	assign wr     = psel & penable & pwrite;
	assign pready = 1'b1;
	assign cfg    = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.kind <= 1'b0;
			cfg_q.cx   <= '0;
			cfg_q.cy   <= '0;
			cfg_q.dx   <= DIR_X_RESET;
			cfg_q.dy   <= '0;
			cfg_q.hw   <= '0;
			cfg_q.hh   <= '0;
		end else if (wr) begin
			unique case (idx)
				REG_KIND:     cfg_q.kind <= pwdata[0];
				REG_CENTER_X: cfg_q.cx   <= pwdata[15:0];
				REG_CENTER_Y: cfg_q.cy   <= pwdata[15:0];
				REG_DIR_X:    cfg_q.dx   <= pwdata[15:0];
				REG_DIR_Y:    cfg_q.dy   <= pwdata[15:0];
				REG_HALF_W:   cfg_q.hw   <= pwdata[14:0];
				REG_HALF_H:   cfg_q.hh   <= pwdata[14:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		prdata = '0;
		unique case (idx)
			REG_KIND:     prdata = {31'd0, cfg_q.kind};
			REG_CENTER_X: prdata = {16'd0, cfg_q.cx};
			REG_CENTER_Y: prdata = {16'd0, cfg_q.cy};
			REG_DIR_X:    prdata = {16'd0, cfg_q.dx};
			REG_DIR_Y:    prdata = {16'd0, cfg_q.dy};
			REG_HALF_W:   prdata = {17'd0, cfg_q.hw};
			REG_HALF_H:   prdata = {17'd0, cfg_q.hh};
			default:      prdata = '0;
		endcase
	end

endmodule
`default_nettype wire

[rtl/scp_geom.sv]
`default_nettype none
module scp_geom (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      in_valid,
	input  logic [1:0]                mode,
	input  logic signed [15:0]        probe_x,
	input  logic signed [15:0]        probe_y,
	input  logic signed [15:0]        probe_dir_x,
	input  logic signed [15:0]        probe_dir_y,
	input  logic [14:0]               probe_half_w,
	input  logic [14:0]               probe_half_h,
	input  scp_pkg::ref_cfg_t         cfg,
	output logic                      valid_s2,
	output scp_pkg::geom_t            geom_s2
);
	import scp_pkg::*;

	logic signed [16:0] tx_c, ty_c;
	logic [15:0]        rsum_c;

	logic               v_s1;
	logic [1:0]         mode_s1;
	logic signed [16:0] tx_s1, ty_s1;
	logic [14:0]        phw_s1, phh_s1;
	logic               flat_s1;
	logic signed [32:0] txrdx_s1, txrdy_s1, tyrdx_s1, tyrdy_s1;
	logic signed [32:0] txpdx_s1, txpdy_s1, typdx_s1, typdy_s1;
	logic signed [31:0] pdxrdx_s1, pdyrdy_s1, pdyrdx_s1, pdxrdy_s1;
	logic signed [31:0] rdx2_s1, rdy2_s1;
	logic signed [31:0] rhwdx_s1, rhwdy_s1, rhhdx_s1, rhhdy_s1;
	logic signed [31:0] phwdx_s1, phwdy_s1, phhdx_s1, phhdy_s1;
	logic signed [33:0] tx2_s1, ty2_s1;
	logic [31:0]        rsq_s1;

	logic signed [33:0] d1, d2, d3, d4;
	logic signed [32:0] c, s;
	logic [30:0]        a_rhwdx, a_rhwdy, a_rhhdx, a_rhhdy;
	logic [30:0]        a_phwdx, a_phwdy, a_phhdx, a_phhdy;
	geom_t              geom_c;

	assign tx_c   = 17'(cfg.cx) - 17'(probe_x);
	assign ty_c   = 17'(cfg.cy) - 17'(probe_y);
	assign rsum_c = (mode == MODE_POINT) ? {1'b0, cfg.hw}
	                                     : 16'(cfg.hw) + 16'(probe_half_w);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1     <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			v_s1     <= in_valid;
			valid_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		mode_s1   <= mode;
		tx_s1     <= tx_c;
		ty_s1     <= ty_c;
		phw_s1    <= probe_half_w;
		phh_s1    <= probe_half_h;
		flat_s1   <= (cfg.dy == 16'sd0) && (probe_dir_y == 16'sd0);
		txrdx_s1  <= tx_c * $signed(cfg.dx);
		txrdy_s1  <= tx_c * $signed(cfg.dy);
		tyrdx_s1  <= ty_c * $signed(cfg.dx);
		tyrdy_s1  <= ty_c * $signed(cfg.dy);
		txpdx_s1  <= tx_c * probe_dir_x;
		txpdy_s1  <= tx_c * probe_dir_y;
		typdx_s1  <= ty_c * probe_dir_x;
		typdy_s1  <= ty_c * probe_dir_y;
		pdxrdx_s1 <= probe_dir_x * $signed(cfg.dx);
		pdyrdy_s1 <= probe_dir_y * $signed(cfg.dy);
		pdyrdx_s1 <= probe_dir_y * $signed(cfg.dx);
		pdxrdy_s1 <= probe_dir_x * $signed(cfg.dy);
		rdx2_s1   <= $signed(cfg.dx) * $signed(cfg.dx);
		rdy2_s1   <= $signed(cfg.dy) * $signed(cfg.dy);
		rhwdx_s1  <= $signed({1'b0, cfg.hw}) * $signed(cfg.dx);
		rhwdy_s1  <= $signed({1'b0, cfg.hw}) * $signed(cfg.dy);
		rhhdx_s1  <= $signed({1'b0, cfg.hh}) * $signed(cfg.dx);
		rhhdy_s1  <= $signed({1'b0, cfg.hh}) * $signed(cfg.dy);
		phwdx_s1  <= $signed({1'b0, probe_half_w}) * probe_dir_x;
		phwdy_s1  <= $signed({1'b0, probe_half_w}) * probe_dir_y;
		phhdx_s1  <= $signed({1'b0, probe_half_h}) * probe_dir_x;
		phhdy_s1  <= $signed({1'b0, probe_half_h}) * probe_dir_y;
		tx2_s1    <= tx_c * tx_c;
		ty2_s1    <= ty_c * ty_c;
		rsq_s1    <= rsum_c * rsum_c;
	end

	assign d1 = 34'(txrdx_s1) + 34'(tyrdy_s1);
	assign d2 = 34'(tyrdx_s1) - 34'(txrdy_s1);
	assign d3 = 34'(txpdx_s1) + 34'(typdy_s1);
	assign d4 = 34'(typdx_s1) - 34'(txpdy_s1);
	assign c  = 33'(pdxrdx_s1) + 33'(pdyrdy_s1);
	assign s  = 33'(pdyrdx_s1) - 33'(pdxrdy_s1);

	assign a_rhwdx = rhwdx_s1[31] ? 31'(-rhwdx_s1) : 31'(rhwdx_s1);
	assign a_rhwdy = rhwdy_s1[31] ? 31'(-rhwdy_s1) : 31'(rhwdy_s1);
	assign a_rhhdx = rhhdx_s1[31] ? 31'(-rhhdx_s1) : 31'(rhhdx_s1);
	assign a_rhhdy = rhhdy_s1[31] ? 31'(-rhhdy_s1) : 31'(rhhdy_s1);
	assign a_phwdx = phwdx_s1[31] ? 31'(-phwdx_s1) : 31'(phwdx_s1);
	assign a_phwdy = phwdy_s1[31] ? 31'(-phwdy_s1) : 31'(phwdy_s1);
	assign a_phhdx = phhdx_s1[31] ? 31'(-phhdx_s1) : 31'(phhdx_s1);
	assign a_phhdy = phhdy_s1[31] ? 31'(-phhdy_s1) : 31'(phhdy_s1);

	always_comb begin
		geom_c.mode   = mode_s1;
		geom_c.abs_tx = tx_s1[16] ? 17'(-tx_s1) : 17'(tx_s1);
		geom_c.abs_ty = ty_s1[16] ? 17'(-ty_s1) : 17'(ty_s1);
		geom_c.dot1   = d1[33] ? 32'(-d1) : 32'(d1);
		geom_c.dot2   = d2[33] ? 32'(-d2) : 32'(d2);
		geom_c.dot3   = d3[33] ? 32'(-d3) : 32'(d3);
		geom_c.dot4   = d4[33] ? 32'(-d4) : 32'(d4);
		geom_c.abs_c  = c[32] ? 32'(-c) : 32'(c);
		geom_c.abs_s  = s[32] ? 32'(-s) : 32'(s);
		geom_c.nrm    = 32'(33'(rdx2_s1) + 33'(rdy2_s1));
		if (cfg.kind) begin
			geom_c.rex = a_rhwdx + a_rhhdy;
			geom_c.rey = a_rhwdy + a_rhhdx;
		end else begin
			geom_c.rex = {2'b00, cfg.hw, 14'd0};
			geom_c.rey = {2'b00, cfg.hw, 14'd0};
		end
		if (mode_s1 == MODE_RECT) begin
			geom_c.pex = a_phwdx + a_phhdy;
			geom_c.pey = a_phwdy + a_phhdx;
		end else begin
			geom_c.pex = {2'b00, phw_s1, 14'd0};
			geom_c.pey = {2'b00, phw_s1, 14'd0};
		end
		geom_c.phw    = phw_s1;
		geom_c.phh    = phh_s1;
		geom_c.cc_hit = 33'(tx2_s1 + ty2_s1) <= 33'(rsq_s1);
		geom_c.flat   = flat_s1;
	end

	always_ff @(posedge clk) begin
		geom_s2 <= geom_c;
	end

endmodule
`default_nettype wire

[rtl/scp_test.sv]
`default_nettype none
module scp_test (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              valid_s2,
	input  scp_pkg::geom_t    geom_s2,
	input  scp_pkg::ref_cfg_t cfg,
	output logic              done,
	output logic              hit
);
	import scp_pkg::*;

	logic [30:0] ptx, pty, ebx, eby;

	logic        v_s3, v_s4;
	logic [1:0]  mode_s3, mode_s4;
	logic        ovl_s3, inbox_s3, cc_s3, flat_s3;
	logic [29:0] gx_s3, gy_s3;
	logic [14:0] rad_s3, phw_s3, phh_s3;
	logic [31:0] dot1_s3, dot2_s3, dot3_s3, dot4_s3;
	logic [46:0] m1a_s3, m1b_s3, m2a_s3, m2b_s3, m3a_s3, m3b_s3, m4a_s3, m4b_s3;
	logic [46:0] pe1_s3, pe2_s3;

	logic        ovl_s4, inbox_s4, cc_s4, flat_s4, sep_s4, pfail_s4;
	logic [59:0] gx2_s4, gy2_s4;
	logic [57:0] rad2_s4;

	logic        cb_hit, hit_c;

	assign ptx = {geom_s2.abs_tx, 14'd0};
	assign pty = {geom_s2.abs_ty, 14'd0};
	assign ebx = cfg.kind ? geom_s2.rex : geom_s2.pex;
	assign eby = cfg.kind ? geom_s2.rey : geom_s2.pey;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			done <= 1'b0;
		end else begin
			v_s3 <= valid_s2;
			v_s4 <= v_s3;
			done <= v_s4;
		end
	end

	always_ff @(posedge clk) begin
		mode_s3  <= geom_s2.mode;
		ovl_s3   <= (32'(ptx) < 32'(geom_s2.rex) + 32'(geom_s2.pex))
		         && (32'(pty) < 32'(geom_s2.rey) + 32'(geom_s2.pey));
		inbox_s3 <= (ptx <= geom_s2.rex) && (pty <= geom_s2.rey);
		cc_s3    <= geom_s2.cc_hit;
		flat_s3  <= geom_s2.flat;
		gx_s3    <= (ptx > ebx) ? 30'(ptx - ebx) : 30'd0;
		gy_s3    <= (pty > eby) ? 30'(pty - eby) : 30'd0;
		rad_s3   <= cfg.kind ? geom_s2.phw : cfg.hw;
		phw_s3   <= geom_s2.phw;
		phh_s3   <= geom_s2.phh;
		dot1_s3  <= geom_s2.dot1;
		dot2_s3  <= geom_s2.dot2;
		dot3_s3  <= geom_s2.dot3;
		dot4_s3  <= geom_s2.dot4;
		m1a_s3   <= geom_s2.phw * geom_s2.abs_c;
		m1b_s3   <= geom_s2.phh * geom_s2.abs_s;
		m2a_s3   <= geom_s2.phw * geom_s2.abs_s;
		m2b_s3   <= geom_s2.phh * geom_s2.abs_c;
		m3a_s3   <= cfg.hw * geom_s2.abs_c;
		m3b_s3   <= cfg.hh * geom_s2.abs_s;
		m4a_s3   <= cfg.hw * geom_s2.abs_s;
		m4b_s3   <= cfg.hh * geom_s2.abs_c;
		pe1_s3   <= cfg.hh * geom_s2.nrm;
		pe2_s3   <= cfg.hw * geom_s2.nrm;
	end

	always_ff @(posedge clk) begin
		mode_s4  <= mode_s3;
		ovl_s4   <= ovl_s3;
		inbox_s4 <= inbox_s3;
		cc_s4    <= cc_s3;
		flat_s4  <= flat_s3;
		gx2_s4   <= gx_s3 * gx_s3;
		gy2_s4   <= gy_s3 * gy_s3;
		rad2_s4  <= {rad_s3, 14'd0} * {rad_s3, 14'd0};
		sep_s4   <= (49'({dot1_s3, 14'd0}) > 49'({cfg.hw, 28'd0}) + 49'(m1a_s3) + 49'(m1b_s3))
		         || (49'({dot2_s3, 14'd0}) > 49'({cfg.hh, 28'd0}) + 49'(m2a_s3) + 49'(m2b_s3))
		         || (49'({dot3_s3, 14'd0}) > 49'({phw_s3, 28'd0}) + 49'(m3a_s3) + 49'(m3b_s3))
		         || (49'({dot4_s3, 14'd0}) > 49'({phh_s3, 28'd0}) + 49'(m4a_s3) + 49'(m4b_s3));
		pfail_s4 <= ((cfg.hw != 15'd0) && (47'({dot2_s3, 14'd0}) > pe1_s3))
		         || ((cfg.hh != 15'd0) && (47'({dot1_s3, 14'd0}) > pe2_s3));
	end

	assign cb_hit = (61'(gx2_s4) + 61'(gy2_s4)) <= 61'(rad2_s4);

	always_comb begin
		hit_c = 1'b0;
		unique case (mode_s4)
			MODE_POINT: begin
				if (!cfg.kind) hit_c = cc_s4;
				else           hit_c = inbox_s4 && ((cfg.dy == 16'sd0) || !pfail_s4);
			end
			MODE_CIRCLE: begin
				hit_c = ovl_s4 && (cfg.kind ? cb_hit : cc_s4);
			end
			MODE_RECT: begin
				hit_c = ovl_s4 && (cfg.kind ? (flat_s4 || !sep_s4) : cb_hit);
			end
			default: hit_c = 1'b0;
		endcase
	end

	always_ff @(posedge clk) begin
		hit <= hit_c;
	end

endmodule
`default_nettype wire

[rtl/shape_pair_collision_test.sv]
`default_nettype none
// Shape pair collision test: one probe (point, circle or rotated rectangle)
// against a reference shape held in configuration registers.
// Configuration: APB-style port, register i at byte address 4*i
// (kind, center x/y, direction x/y, half width/radius, half height).
// Write registers only while no test is in flight.
// Command channel: a probe transfer happens at a rising edge with start high
// and busy low. busy is always low, so a new probe may enter every cycle.
// Result channel: done is high for one cycle with hit valid in that cycle;
// the receiver cannot stall, so results are never held.
// Pipeline: the transfer edge loads S1, and done rises as S5 is loaded
// (S1 products, S2 sums and extents, S3 bound products, S4 squares and axis
// compares, S5 final decision). Throughput: one probe per cycle, set by the
// fully pipelined multiplier datapath.
// Reset: clears all stage valid bits and restores the reference registers
// to a unit x direction circle of radius zero at the origin.
module shape_pair_collision_test (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      start,
	output logic                      busy,
	input  logic [1:0]                mode,
	input  logic signed [15:0]        probe_x,
	input  logic signed [15:0]        probe_y,
	input  logic signed [15:0]        probe_dir_x,
	input  logic signed [15:0]        probe_dir_y,
	input  logic [14:0]               probe_half_w,
	input  logic [14:0]               probe_half_h,
	output logic                      done,
	output logic                      hit,
	input  logic                      psel,
	input  logic                      penable,
	input  logic                      pwrite,
	input  logic [scp_pkg::AddrW-1:0] paddr,
	input  logic [31:0]               pwdata,
	output logic [31:0]               prdata,
	output logic                      pready
);
	import scp_pkg::*;

	ref_cfg_t cfg;
	geom_t    geom_s2;
	logic     valid_s2;

	assign busy = 1'b0;

	scp_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	scp_geom u_geom (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (start & ~busy),
		.mode         (mode),
		.probe_x      (probe_x),
		.probe_y      (probe_y),
		.probe_dir_x  (probe_dir_x),
		.probe_dir_y  (probe_dir_y),
		.probe_half_w (probe_half_w),
		.probe_half_h (probe_half_h),
		.cfg          (cfg),
		.valid_s2     (valid_s2),
		.geom_s2      (geom_s2)
	);

	scp_test u_test (
		.clk      (clk),
		.arst_n   (arst_n),
		.valid_s2 (valid_s2),
		.geom_s2  (geom_s2),
		.cfg      (cfg),
		.done     (done),
		.hit      (hit)
	);

endmodule
`default_nettype wire
